@@ rtl/lmfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_pkg - shared types and constants
// Defaults, field widths, pin table and sequencer codes of the LED matrix
// bit-plane framebuffer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

	// default geometry
	localparam int LMFB_ROW_WORDS    = 64;
	localparam int LMFB_PLANES       = 8;
	localparam int LMFB_SCAN_ROWS    = 16;
	localparam int LMFB_PANEL_BUSES  = 2;
	localparam int LMFB_BUFFER_COUNT = 2;

	// field widths
	localparam int LMFB_COL_W    = 6;
	localparam int LMFB_ROW_W    = 8;
	localparam int LMFB_COLOR_W  = 8;
	localparam int LMFB_IDX_W    = 13;
	localparam int LMFB_WORD_W   = 16;
	localparam int LMFB_STEP_W   = $clog2(LMFB_ROW_W);
	localparam int LMFB_CHANNELS = 3;

	typedef logic [3:0] pin_t;

	// pin per (channel + 3 * bus): R0 G0 B0 R1 G1 B1
	localparam pin_t PIN_OF [6] = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd8};

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_SWAP  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_RD,
		ST_WR,
		ST_READ,
		ST_RDATA
	} state_t;

	// per-plane control for the bit merge unit
	typedef struct packed {
		logic [LMFB_CHANNELS-1:0] rgb;  // {blue, green, red} bit of this plane
		logic                     bus;
	} merge_ctl_t;

endpackage

@@ rtl/led_matrix_bitplane_framebuffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_bitplane_framebuffer - multi-buffered bit-plane framebuffer
// Pixel writes land in the write buffer as per-plane pin bits, swaps rotate
// the buffers, reads return one pin word of the display buffer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  tuser: func; tdata: column, pixel_row,
//                                   red, green, blue, read_index
// m_axis    out  m_tvalid/m_tready  tdata: read_word
//
// Pixel write: accept in ST_IDLE, split the row by SCAN_ROWS in ST_DIV
// (reciprocal multiply for the quotient, then the remainder), form the
// address in ST_ADDR, then per plane ST_RD and ST_WR on the frame RAM
// (read, then write back the merged word). All three colours of a plane
// share one read-modify-write.
// Swap and no-op end in the accept state; a read passes ST_READ and
// ST_RDATA, waiting in ST_READ for the output register to drain.
// After reset the frame RAM is cleared, one word per cycle, all
// BUFFER_COUNT*SCAN_ROWS*PLANES*ROW_WORDS words (16384 at the defaults).
// The output register holds a read word while new writes and swaps go on.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_framebuffer
	import lmfb_pkg::*;
#(
	parameter int ROW_WORDS    = LMFB_ROW_WORDS,
	parameter int PLANES       = LMFB_PLANES,
	parameter int SCAN_ROWS    = LMFB_SCAN_ROWS,
	parameter int PANEL_BUSES  = LMFB_PANEL_BUSES,
	parameter int BUFFER_COUNT = LMFB_BUFFER_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // column[5:0], pixel_row[13:6], red[21:14],
	                               // green[29:22], blue[37:30], read_index[50:38]
	input  logic [1:0]  s_tuser,   // func[1:0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_word[15:0]
);

	// geometry
	localparam int ROW_PLANE   = ROW_WORDS * PLANES;          // words per scan row
	localparam int BUF_WORDS   = ROW_PLANE * SCAN_ROWS;       // words per buffer
	localparam int STORE_WORDS = BUF_WORDS * BUFFER_COUNT;
	localparam int AW          = $clog2(STORE_WORDS);
	localparam int BW          = $clog2(BUFFER_COUNT);
	localparam int PW          = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int RMW         = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
	localparam int CSHIFT      = LMFB_COLOR_W - PLANES;      // top plane to bit 7

	// row / SCAN_ROWS as (row * DIV_RECIP) >> DIV_SHIFT, exact for 8-bit rows
	localparam int DIV_STEPS = 2;
	localparam int DIV_LOG   = $clog2(SCAN_ROWS);
	localparam int DIV_SHIFT = LMFB_ROW_W + DIV_LOG;
	localparam int DIV_RECIP = ((1 << DIV_SHIFT) + SCAN_ROWS - 1) / SCAN_ROWS;
	localparam int RCP_W     = LMFB_ROW_W + 1;
	localparam int DPW       = LMFB_ROW_W + RCP_W;

	// input field unpack
	logic [LMFB_COL_W-1:0]   in_column;
	logic [LMFB_ROW_W-1:0]   in_row;
	logic [LMFB_COLOR_W-1:0] in_red;
	logic [LMFB_COLOR_W-1:0] in_green;
	logic [LMFB_COLOR_W-1:0] in_blue;
	logic [LMFB_IDX_W-1:0]   in_idx;
	func_t                   in_func;

	assign in_column = s_tdata[5:0];
	assign in_row    = s_tdata[13:6];
	assign in_red    = s_tdata[21:14];
	assign in_green  = s_tdata[29:22];
	assign in_blue   = s_tdata[37:30];
	assign in_idx    = s_tdata[50:38];
	assign in_func   = func_t'(s_tuser);

	// sequencer state
	state_t state_q, state_d;

	// control registers
	logic [AW-1:0]          clr_q;
	logic [LMFB_STEP_W-1:0] step_q;
	logic [PW-1:0]          plane_q;
	logic [BW-1:0]          display_q;
	logic [BW-1:0]          write_q;
	logic                   m_tvalid_q;

	// payload registers
	logic [LMFB_COL_W-1:0]   col_q;
	logic [LMFB_ROW_W-1:0]   row_q;      // dividend
	logic [LMFB_ROW_W-1:0]   quo_q;      // row / SCAN_ROWS
	logic [RMW-1:0]          rem_q;      // ends as scan row
	logic                    qbit_q;     // quotient LSB, ends as bus select
	logic [LMFB_COLOR_W-1:0] red_q;
	logic [LMFB_COLOR_W-1:0] green_q;
	logic [LMFB_COLOR_W-1:0] blue_q;
	logic [AW-1:0]           addr_q;
	logic [LMFB_IDX_W-1:0]   idx_q;
	logic                    idx_ok_q;
	logic [LMFB_WORD_W-1:0]  m_tdata_q;

	// RAM port signals
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [LMFB_WORD_W-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [LMFB_WORD_W-1:0] ram_rdata;

	// shared units
	logic [DPW-1:0]         div_prod;
	logic [LMFB_ROW_W-1:0]  div_quo;
	logic [LMFB_ROW_W-1:0]  div_back;
	logic [RMW-1:0]         rem_next;
	merge_ctl_t             mctl;
	logic [LMFB_WORD_W-1:0] merged;
	logic [AW-1:0]          read_addr;
	logic                   out_free;

	// row split: quotient first, remainder from it on the next step
	assign div_prod = DPW'(row_q) * DPW'(DIV_RECIP);
	assign div_quo  = LMFB_ROW_W'(div_prod >> DIV_SHIFT);
	assign div_back = quo_q * LMFB_ROW_W'(SCAN_ROWS);
	assign rem_next = RMW'(row_q - div_back);

	// this plane's colour bits, top plane first
	assign mctl.rgb = {blue_q[LMFB_COLOR_W-1], green_q[LMFB_COLOR_W-1],
	                   red_q[LMFB_COLOR_W-1]};
	assign mctl.bus = (PANEL_BUSES > 1) ? qbit_q : 1'b0;

	lmfb_merge u_merge (
		.word_in  (ram_rdata),
		.ctl      (mctl),
		.word_out (merged)
	);

	assign read_addr = AW'(display_q) * AW'(BUF_WORDS) + AW'(idx_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = merged;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(STORE_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_func) inside
						FUNC_WRITE: begin
							if (int'(in_column) < ROW_WORDS) begin
								state_d = ST_DIV;
							end
						end
						FUNC_READ: state_d = ST_READ;
						FUNC_SWAP, FUNC_NOP: state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (step_q == LMFB_STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: state_d = ST_RD;
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				ram_we = 1'b1;
				if (plane_q == PW'(PLANES - 1)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_READ: begin
				// issue only once the output register is sure to be free
				if (out_free) begin
					ram_re    = idx_ok_q;
					ram_raddr = read_addr;
					state_d   = ST_RDATA;
				end
			end
			ST_RDATA: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			step_q     <= '0;
			plane_q    <= '0;
			display_q  <= '0;
			write_q    <= BW'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE) begin
				step_q  <= '0;
				plane_q <= '0;
			end
			if (state_q == ST_DIV) begin
				step_q <= step_q + LMFB_STEP_W'(1);
			end
			if (state_q == ST_WR) begin
				plane_q <= plane_q + PW'(1);
			end
			if (s_tvalid && s_tready && in_func == FUNC_SWAP) begin
				display_q <= write_q;
				if (write_q == BW'(BUFFER_COUNT - 1)) begin
					write_q <= '0;
				end else begin
					write_q <= write_q + BW'(1);
				end
			end
			if (state_q == ST_RDATA) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q    <= in_column;
				row_q    <= in_row;
				rem_q    <= '0;
				qbit_q   <= 1'b0;
				red_q    <= in_red << CSHIFT;
				green_q  <= in_green << CSHIFT;
				blue_q   <= in_blue << CSHIFT;
				idx_q    <= in_idx;
				idx_ok_q <= (int'(in_idx) < BUF_WORDS);
			end
			ST_DIV: begin
				if (step_q == '0) begin
					quo_q <= div_quo;
				end else begin
					rem_q  <= rem_next;
					qbit_q <= quo_q[0];
				end
			end
			ST_ADDR: begin
				addr_q <= AW'(write_q) * AW'(BUF_WORDS) + AW'(rem_q) * AW'(ROW_PLANE)
				          + AW'(col_q);
			end
			ST_WR: begin
				addr_q  <= addr_q + AW'(ROW_WORDS);
				red_q   <= red_q << 1;
				green_q <= green_q << 1;
				blue_q  <= blue_q << 1;
			end
			ST_RDATA: begin
				m_tdata_q <= idx_ok_q ? ram_rdata : '0;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	lmfb_ram #(
		.WIDTH (LMFB_WORD_W),
		.DEPTH (STORE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write-back hits the word read in the previous cycle
	a_rmw_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> ram_waddr == $past(ram_raddr))
		else $error("write-back address differs from read address");

	// display and write buffers never coincide
	a_buf_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		display_q != write_q)
		else $error("display buffer equals write buffer");

	// no RAM write on the read path
	a_read_no_we: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_RDATA) |-> !ram_we)
		else $error("RAM written during display read");

	// a result is loaded only into an empty output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDATA |-> !m_tvalid_q)
		else $error("output word overwritten");

	// output valid appears only after a read completes
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_RDATA))
		else $error("output valid without read");

endmodule

@@ rtl/lmfb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lmfb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lmfb_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_merge - pin bit merge unit
// Drops the three colour bits of one plane onto their pins of a pin word.
// ----------------------------------------------------------------------------
module lmfb_merge
	import lmfb_pkg::*;
(
	input  logic [LMFB_WORD_W-1:0] word_in,
	input  merge_ctl_t             ctl,
	output logic [LMFB_WORD_W-1:0] word_out
);

	always_comb begin
		logic [2:0] sel;
		word_out = word_in;
		for (int c = 0; c < LMFB_CHANNELS; c++) begin
			sel = 3'(c) + (ctl.bus ? 3'd3 : 3'd0);
			word_out[PIN_OF[sel]] = ctl.rgb[c];
		end
	end

endmodule

@@ tb/tb_led_matrix_bitplane_framebuffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_bitplane_framebuffer - self-checking bench for the framebuffer
// Drives pixel writes, buffer swaps, display reads and no-ops into the slave
// stream, keeps a shadow copy of all frame buffers and the buffer pointers,
// and checks every read word on the master stream in order. Both streams
// stall at random, apart from a closing stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_led_matrix_bitplane_framebuffer;
	import lmfb_pkg::*;

	// geometry at the block defaults
	localparam int ROW_WORDS    = LMFB_ROW_WORDS;
	localparam int PLANES       = LMFB_PLANES;
	localparam int SCAN_ROWS    = LMFB_SCAN_ROWS;
	localparam int PANEL_BUSES  = LMFB_PANEL_BUSES;
	localparam int BUFFER_COUNT = LMFB_BUFFER_COUNT;
	localparam int BUF_WORDS    = ROW_WORDS * PLANES * SCAN_ROWS;
	localparam int STORE_WORDS  = BUF_WORDS * BUFFER_COUNT;

	// pin per (channel + 3 * bus): R0 G0 B0 R1 G1 B1
	localparam int PIN_BITS [6] = '{0, 1, 3, 4, 5, 8};

	localparam int MAX_REPORTS  = 10;
	// drain time: covers a pixel write, the longest job, with margin
	localparam int DRAIN_CYCLES = 2 * PLANES + 30;

	// one command word on the slave stream
	typedef struct packed {
		func_t       func;
		logic [5:0]  column;
		logic [7:0]  pixel_row;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] read_index;
	} fb_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // column, pixel_row, red, green, blue, read_index
	logic [1:0]  s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // read_word

	// shadow of the frame store and buffer pointers
	logic [15:0] shadow_fb [STORE_WORDS];
	int          shadow_disp;
	int          shadow_wr;

	logic [15:0] pending_reads [$];  // read words still owed by the block
	logic [13:0] painted [$];        // recent {pixel_row, column} written
	int          word_errors;
	bit          steady;             // no stalls on either side when set

	led_matrix_bitplane_framebuffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far past the slowest legal run (RAM clear + ~900 stalled commands)
	initial begin
		#5_000_000;
		$display("tb_led_matrix_bitplane_framebuffer: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// word of a given plane for a pixel, within one buffer
	function automatic logic [12:0] word_index(logic [7:0] row, logic [5:0] col, int plane);
		return 13'(((int'(row) % SCAN_ROWS) * PLANES + plane) * ROW_WORDS + int'(col));
	endfunction

	// apply one accepted command to the shadow state; reads queue their word
	function automatic void predict_frame(fb_cmd_t cmd);
		int         scan;
		int         bus;
		int         base;
		int         addr;
		int         pin;
		logic [7:0] color [3];

		color[0] = cmd.red;
		color[1] = cmd.green;
		color[2] = cmd.blue;
		case (cmd.func)
			FUNC_WRITE: begin
				if (int'(cmd.column) < ROW_WORDS && shadow_wr < BUFFER_COUNT) begin
					scan = int'(cmd.pixel_row) % SCAN_ROWS;
					bus  = (int'(cmd.pixel_row) / SCAN_ROWS) % PANEL_BUSES;
					base = shadow_wr * BUF_WORDS + scan * PLANES * ROW_WORDS
					       + int'(cmd.column);
					for (int c = 0; c < 3; c++) begin
						pin = PIN_BITS[(c + 3 * bus) % 6];
						// plane 0 carries the top color bit
						for (int p = 0; p < PLANES; p++) begin
							addr = base + p * ROW_WORDS;
							if (addr < STORE_WORDS)
								shadow_fb[addr][pin] = color[c][PLANES - 1 - p];
						end
					end
				end
				painted.push_back({cmd.pixel_row, cmd.column});
				if (painted.size() > 32)
					void'(painted.pop_front());
			end
			FUNC_SWAP: begin
				shadow_disp = shadow_wr % BUFFER_COUNT;
				shadow_wr   = (shadow_disp + 1) % BUFFER_COUNT;
			end
			FUNC_READ: begin
				if (int'(cmd.read_index) < BUF_WORDS)
					pending_reads.push_back(
						shadow_fb[shadow_disp * BUF_WORDS + int'(cmd.read_index)]);
				else
					pending_reads.push_back(16'h0000);
			end
			default: ;  // no-op: nothing changes, no word back
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Slave side
	// ------------------------------------------------------------------------

	// present one command, hold it until accepted, then predict
	task automatic send_word(fb_cmd_t cmd);
		s_tuser  <= cmd.func;
		s_tdata  <= {5'b0, cmd.read_index, cmd.blue, cmd.green, cmd.red,
		             cmd.pixel_row, cmd.column};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_frame(cmd);
	endtask

	task automatic sender_gap();
		int n;

		n = $urandom_range(1, 14);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic fb_cmd_t make_cmd(func_t f, logic [5:0] col, logic [7:0] row,
	                                     logic [7:0] r, logic [7:0] g, logic [7:0] b,
	                                     logic [12:0] idx);
		fb_cmd_t cmd;

		cmd.func       = f;
		cmd.column     = col;
		cmd.pixel_row  = row;
		cmd.red        = r;
		cmd.green      = g;
		cmd.blue       = b;
		cmd.read_index = idx;
		return cmd;
	endfunction

	// random command; fields a command ignores still carry random bits
	function automatic fb_cmd_t random_cmd();
		fb_cmd_t     cmd;
		int          pick;
		logic [13:0] spot;

		cmd.column     = 6'($urandom);
		cmd.pixel_row  = 8'($urandom);
		cmd.red        = 8'($urandom);
		cmd.green      = 8'($urandom);
		cmd.blue       = 8'($urandom);
		cmd.read_index = 13'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			cmd.func = FUNC_WRITE;
			// crowd half the writes into a few columns so both buses share words
			if ($urandom_range(0, 1) == 1)
				cmd.column = 6'($urandom_range(0, 3));
		end else if (pick < 55) begin
			cmd.func = FUNC_SWAP;
		end else if (pick < 95) begin
			cmd.func = FUNC_READ;
			// mostly read back words that recent writes touched
			if (painted.size() > 0 && $urandom_range(0, 9) < 7) begin
				spot = painted[$urandom_range(0, painted.size() - 1)];
				cmd.read_index = word_index(spot[13:6], spot[5:0],
				                            $urandom_range(0, PLANES - 1));
			end
		end else begin
			cmd.func = FUNC_NOP;
		end
		return cmd;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (!steady && $urandom_range(0, 3) == 0)
				sender_gap();
			send_word(random_cmd());
		end
	endtask

	// ------------------------------------------------------------------------
	// Master side: the sink stalls in random bursts, none once steady
	// ------------------------------------------------------------------------
	initial begin : sink_stalls
		int stall_left;

		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// every read word must match the oldest pending one
	always @(posedge clk) begin : check_words
		logic [15:0] want;

		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				word_errors++;
				if (word_errors <= MAX_REPORTS)
					$display("%0t: read word %04h with nothing pending", $time, m_tdata);
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata !== want) begin
					word_errors++;
					if (word_errors <= MAX_REPORTS)
						$display("%0t: read word mismatch: expected %04h, got %04h",
						         $time, want, m_tdata);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// RAM comes out of reset cleared; a no-op returns nothing
	task automatic test_cleared_memory();
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
		send_word(make_cmd(FUNC_READ, 6'd63, 8'hff, 8'hff, 8'hff, 8'hff, 13'h1fff));
		send_word(make_cmd(FUNC_NOP, 6'd63, 8'hff, 8'hff, 8'hff, 8'hff, 13'h1fff));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'h1000));
	endtask

	// corner pixels, both buses merged into one word, top and bottom planes
	task automatic test_pixel_extremes();
		send_word(make_cmd(FUNC_WRITE, 6'd63, 8'd255, 8'hff, 8'h00, 8'ha5, 13'd0));
		send_word(make_cmd(FUNC_WRITE, 6'd0, 8'd0, 8'h00, 8'hff, 8'h5a, 13'h1fff));
		// row 16 is bus 1 on scan row 0: same words as row 0
		send_word(make_cmd(FUNC_WRITE, 6'd0, 8'd16, 8'h81, 8'h42, 8'h24, 13'd0));
		send_word(make_cmd(FUNC_SWAP, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd0, 6'd0, 0)));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd0, 6'd0, PLANES - 1)));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd255, 6'd63, 0)));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd255, 6'd63, PLANES - 1)));
	endtask

	// writes stay hidden until the next swap; swaps rotate back around
	task automatic test_buffer_swap();
		send_word(make_cmd(FUNC_WRITE, 6'd5, 8'd40, 8'h80, 8'h01, 8'hff, 13'd0));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd40, 6'd5, 0)));
		send_word(make_cmd(FUNC_SWAP, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd40, 6'd5, 0)));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00,
		                   word_index(8'd40, 6'd5, PLANES - 1)));
		send_word(make_cmd(FUNC_NOP, 6'd17, 8'h3c, 8'h99, 8'h66, 8'hc3, 13'h0abc));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
		send_word(make_cmd(FUNC_SWAP, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
		send_word(make_cmd(FUNC_READ, 6'd0, 8'd0, 8'h00, 8'h00, 8'h00, 13'd0));
	endtask

	// mixed traffic with stalls on both sides
	task automatic test_random_traffic();
		steady = 1'b0;
		run_random(800);
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		steady = 1'b1;
		run_random(100);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		for (int i = 0; i < STORE_WORDS; i++)
			shadow_fb[i] = 16'h0000;
		shadow_disp = 0;
		shadow_wr   = 1 % BUFFER_COUNT;
		word_errors = 0;
		steady      = 1'b0;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= FUNC_NOP;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// s_tready stays low through the RAM clear; send_word waits it out
		test_cleared_memory();
		test_pixel_extremes();
		test_buffer_swap();
		test_random_traffic();
		test_full_rate();
		s_tvalid <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (word_errors == 0 && pending_reads.size() == 0)
			$display("tb_led_matrix_bitplane_framebuffer: PASS");
		else
			$display("tb_led_matrix_bitplane_framebuffer: FAIL");
		$finish;
	end

endmodule
